### sv/cp1252u8_pkg.sv
// ----------------------------------------------------------------------------
// cp1252u8_pkg
// shared types, constants and the windows-1252 upper table for the transcoder
// ----------------------------------------------------------------------------
package cp1252u8_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 16;
    localparam int unsigned SEQ_MAX  = 3;
    localparam int unsigned IDX_W    = 2;

    // index of the last byte of a sequence
    localparam logic [IDX_W-1:0] LAST_ONE   = 2'd0;
    localparam logic [IDX_W-1:0] LAST_TWO   = 2'd1;
    localparam logic [IDX_W-1:0] LAST_THREE = 2'd2;

    localparam logic [CP_W-1:0] CP_TWO_BYTE   = 16'd128;
    localparam logic [CP_W-1:0] CP_THREE_BYTE = 16'd2048;

    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'he0;
    localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;

    // code points for 0x80 to 0x9f, undefined slots give the replacement char
    localparam logic [CP_W-1:0] W1252_HIGH [32] = '{
        16'h20ac, 16'hfffd, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
        16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hfffd, 16'h017d, 16'hfffd,
        16'hfffd, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
        16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'hfffd, 16'h017e, 16'h0178
    };

    // one encoded sequence, byte 0 goes out first
    typedef struct packed {
        logic [IDX_W-1:0]                last_idx;
        logic [SEQ_MAX-1:0][BYTE_W-1:0]  bytes;
    } seq_t;

endpackage

### sv/cp1252u8_front.sv
// ----------------------------------------------------------------------------
// cp1252u8_front
// maps source bytes to utf-8 via a code point, or passes them raw if disabled
// ----------------------------------------------------------------------------
module cp1252u8_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    output logic                  push_valid,
    input  logic                  push_ready,
    output cp1252u8_pkg::seq_t    push_entry
);

    logic                              enable_reg;
    logic                              enable_next;
    logic [cp1252u8_pkg::CP_W-1:0]     cp;
    cp1252u8_pkg::seq_t                seq;

    always_comb begin
        enable_next = enable_reg;
        if (cfg_valid) begin
            enable_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else begin
            enable_reg <= enable_next;
        end
    end

    always_comb begin
        if (s_in_byte inside {[8'h80:8'h9f]}) begin
            cp = cp1252u8_pkg::W1252_HIGH[s_in_byte[4:0]];
        end else begin
            cp = {8'h00, s_in_byte};
        end
    end

    always_comb begin
        seq.bytes    = '0;
        seq.last_idx = cp1252u8_pkg::LAST_ONE;
        if (!enable_reg) begin
            seq.bytes[0] = s_in_byte;
        end else if (cp < cp1252u8_pkg::CP_TWO_BYTE) begin
            seq.bytes[0] = cp[7:0];
        end else if (cp < cp1252u8_pkg::CP_THREE_BYTE) begin
            seq.last_idx = cp1252u8_pkg::LAST_TWO;
            seq.bytes[0] = cp1252u8_pkg::LEAD_TWO  | {3'b000, cp[10:6]};
            seq.bytes[1] = cp1252u8_pkg::CONT_MARK | {2'b00, cp[5:0]};
        end else begin
            seq.last_idx = cp1252u8_pkg::LAST_THREE;
            seq.bytes[0] = cp1252u8_pkg::LEAD_THREE | {4'h0, cp[15:12]};
            seq.bytes[1] = cp1252u8_pkg::CONT_MARK  | {2'b00, cp[11:6]};
            seq.bytes[2] = cp1252u8_pkg::CONT_MARK  | {2'b00, cp[5:0]};
        end
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign push_entry = seq;

endmodule

### sv/cp1252u8_queue.sv
// ----------------------------------------------------------------------------
// cp1252u8_queue
// short fifo of encoded sequences between front and back
// ----------------------------------------------------------------------------
module cp1252u8_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  cp1252u8_pkg::seq_t    push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output cp1252u8_pkg::seq_t    pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cp1252u8_pkg::seq_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### sv/cp1252u8_back.sv
// ----------------------------------------------------------------------------
// cp1252u8_back
// holds one sequence and sends its bytes out one per cycle while m_ready is high
// ----------------------------------------------------------------------------
module cp1252u8_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  cp1252u8_pkg::seq_t    pop_entry,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_seq_last
);

    cp1252u8_pkg::seq_t                  cur_reg, cur_next;
    logic [cp1252u8_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                                valid_reg, valid_next;
    logic                                fire, last;

    assign last       = (idx_reg == cur_reg.last_idx);
    assign fire       = valid_reg && m_ready;
    assign pop_ready  = !valid_reg || (m_ready && last);
    assign m_valid    = valid_reg;
    assign m_out_byte = cur_reg.bytes[idx_reg];
    assign m_seq_last = last;

    always_comb begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (pop_valid && pop_ready) begin
            cur_next   = pop_entry;
            idx_next   = '0;
            valid_next = 1'b1;
        end else if (fire && last) begin
            valid_next = 1'b0;
        end else if (fire) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

### sv/cp1252_to_utf8_transcoder_core.sv
// ----------------------------------------------------------------------------
// cp1252_to_utf8_transcoder_core
// windows-1252 / latin-1 byte stream to utf-8 byte stream
// ----------------------------------------------------------------------------
// path: an accepted input request is written into the queue, then loaded into the
//   back register once the back is free; the first output byte is valid from there
// throughput: one output byte per cycle while m_ready is high; an item has 1, 2 or
//   3 bytes (its utf-8 length); the single output byte lane sets this figure
// input is taken every cycle while the queue has room, even when output stalls
// reset: synchronous active-low aresetn empties queue and output, enable goes to 0
// ----------------------------------------------------------------------------
module cp1252_to_utf8_transcoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: transcode enable
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_wdata,
    // source bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    // utf-8 bytes
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_seq_last
);

    // front to queue
    logic                 push_valid;
    logic                 push_ready;
    cp1252u8_pkg::seq_t   push_entry;

    // queue to back
    logic                 pop_valid;
    logic                 pop_ready;
    cp1252u8_pkg::seq_t   pop_entry;

    // the enable register takes a write request in any cycle
    assign cfg_ready = 1'b1;

    // front: table lookup and utf-8 encoding of one byte per request
    cp1252u8_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // queue: decouples encoding from the byte-serial output
    cp1252u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // back: walks the held sequence, marks the final byte
    cp1252u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_seq_last (m_seq_last)
    );

endmodule

### sv/cp1252u8_checker.sv
// ----------------------------------------------------------------------------
// cp1252u8_checker
// port-level checks on the transcoder output stream
// ----------------------------------------------------------------------------
module cp1252u8_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_seq_last
);

    // stalled output request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_seq_last))
        else $error("output request changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // rest of a sequence follows at once and is a continuation byte
    a_cont_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_seq_last |=> m_valid && (m_out_byte[7:6] == 2'b10))
        else $error("missing continuation byte");

    // a byte that is not last is never plain ascii
    a_nonlast_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_seq_last |-> m_out_byte[7])
        else $error("ascii byte inside a multi-byte sequence");

endmodule

bind cp1252_to_utf8_transcoder_core cp1252u8_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_seq_last (m_seq_last)
);
